### hdl/knn_pkg.sv
// Shared types and constants for the k-NN top-k list with majority vote.
// No dependencies; imported by every module of the block.
`default_nettype none

package knn_pkg;

  localparam logic [1:0] OP_OFFER = 2'd0;
  localparam logic [1:0] OP_VOTE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Empty-slot score, -2.0 in Q2.14
  localparam logic signed [15:0] SENTINEL_SCORE = 16'sh8000;
  localparam logic [4:0]         K_RESET        = 5'd16;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] score;
    logic [3:0]         class_id;
  } in_t;

  typedef struct packed {
    logic [3:0] best_class;
    logic       found;
  } out_t;

  typedef struct packed {
    logic offer;
    logic clear;
    logic vote_load;
    logic vote_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic vote_done;
  } status_t;

endpackage

`default_nettype wire

### hdl/knn_top_k_insert_and_vote_top.sv
// Top level of the k-NN top-k list with majority vote.
// Depends on knn_pkg, knn_ctrl and knn_dp.
//
// Usage:
//   Input channel: an item (in_data: opcode, score, class_id) is taken at a
//   rising edge with start high and busy low. Offer inserts a Q2.14 score with
//   its class into the descending top-k list; clear empties it; vote returns
//   the majority class of the filled entries (lowest class id on a tie).
//   Offer, clear and the unused opcode keep busy low, so such items can be
//   taken on every cycle.
//   A vote raises busy while the class counters take the filled entries
//   (at most k), one kept class per cycle. The result appears on out_data
//   with out_valid high for exactly one cycle, in the first cycle with busy
//   low again; it must be taken then, there is no stall.
//   Config channel: cfg_data (k_in_use) is written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write only while idle.
//   Reset (rst_n low, synchronous): the list is empty, k_in_use is 16,
//   the controller is idle and out_valid is low.
`default_nettype none

module knn_top_k_insert_and_vote_top
  import knn_pkg::*;
#(
  parameter int MAX_K       = 16,
  parameter int NUM_CLASSES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_t        in_data,
  output logic            out_valid,
  output out_t            out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [4:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  knn_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_data.opcode),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  knn_dp #(
    .MAX_K       (MAX_K),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .item      (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hdl/knn_ctrl.sv
// Controller of the k-NN top-k block: accepts items and sequences the vote count.
// Depends on knn_pkg; drives knn_dp through cmd_t and reads status_t.
`default_nettype none

module knn_ctrl
  import knn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] opcode,
  input  wire status_t    status,
  output logic            busy,
  output cmd_t            cmd
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_COUNT = 1'b1;

  logic state_r;
  logic state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (opcode)
            OP_OFFER: begin
              cmd.offer = 1'b1;
            end
            OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            OP_VOTE: begin
              cmd.vote_load = 1'b1;
              state_nxt     = ST_COUNT;
            end
            default: begin
              // unused opcode: drop the item
            end
          endcase
        end
      end
      ST_COUNT: begin
        busy = 1'b1;
        if (status.vote_done) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.vote_step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/knn_dp.sv
// Datapath of the k-NN top-k block: sorted score/class lanes, fill count,
// class vote counters and the result register. Depends on knn_pkg.
`default_nettype none

module knn_dp
  import knn_pkg::*;
#(
  parameter int MAX_K       = 16,
  parameter int NUM_CLASSES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       cmd,
  output status_t         status,
  input  wire in_t        item,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_data,
  output logic            out_valid,
  output out_t            out_data
);

  localparam int CNT_W = $clog2(MAX_K + 1);
  localparam int NV    = (NUM_CLASSES < 16) ? NUM_CLASSES : 16;
  localparam int VW    = $clog2(NV);

  logic [4:0]         k_in_use_r;
  logic [CNT_W-1:0]   fill_r;
  logic signed [15:0] score_r [MAX_K];
  logic [3:0]         class_r [MAX_K];
  logic [3:0]         snap_r  [MAX_K];
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   nf_r;
  logic [CNT_W-1:0]   cnt_r   [NV];
  logic [CNT_W-1:0]   most_r;
  logic [3:0]         best_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic [CNT_W-1:0] eff_k;
  logic [CNT_W-1:0] fill_eff;
  logic             full;
  logic [MAX_K-1:0] ge;
  logic [MAX_K-1:0] keep;
  logic [MAX_K-1:0] shift_ok;
  logic [MAX_K-1:0] is_last;
  logic             last_ge;
  logic             do_ins;

  // Effective k: zero acts as one, above capacity saturates
  always_comb begin
    if (k_in_use_r == 5'd0) begin
      eff_k = CNT_W'(1);
    end else if (int'(k_in_use_r) > MAX_K) begin
      eff_k = CNT_W'(MAX_K);
    end else begin
      eff_k = CNT_W'(k_in_use_r);
    end
  end

  assign fill_eff = (fill_r < eff_k) ? fill_r : eff_k;
  assign full     = (fill_eff == eff_k);

  for (genvar gi = 0; gi < MAX_K; gi++) begin : g_cmp
    assign ge[gi]       = ($signed(score_r[gi]) >= $signed(item.score));
    assign keep[gi]     = (gi < int'(fill_eff)) && ge[gi];
    assign shift_ok[gi] = (gi <= int'(fill_eff)) && (gi < int'(eff_k));
    assign is_last[gi]  = (gi == int'(eff_k) - 1);
  end

  assign last_ge = |(ge & is_last);
  assign do_ins  = cmd.offer && (item.score != SENTINEL_SCORE) && !(full && last_ge);

  // Lanes ahead of the insert point hold, the insert point takes the item,
  // lanes behind it shift down by one up to the last usable lane.
  for (genvar gi = 0; gi < MAX_K; gi++) begin : g_lane
    if (gi == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (do_ins && !keep[0]) begin
          score_r[0] <= item.score;
          class_r[0] <= item.class_id;
        end
        if (cmd.vote_load) begin
          snap_r[0] <= class_r[0];
        end else if (cmd.vote_step && MAX_K > 1) begin
          snap_r[0] <= snap_r[(MAX_K > 1) ? 1 : 0];
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (do_ins && !keep[gi]) begin
          if (keep[gi-1]) begin
            score_r[gi] <= item.score;
            class_r[gi] <= item.class_id;
          end else if (shift_ok[gi]) begin
            score_r[gi] <= score_r[gi-1];
            class_r[gi] <= class_r[gi-1];
          end
        end
        if (cmd.vote_load) begin
          snap_r[gi] <= class_r[gi];
        end else if (cmd.vote_step && gi < MAX_K - 1) begin
          snap_r[gi] <= snap_r[(gi < MAX_K - 1) ? gi + 1 : gi];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      k_in_use_r <= K_RESET;
    end else begin
      if (cmd.clear) begin
        fill_r <= '0;
      end else if (do_ins) begin
        fill_r <= full ? eff_k : CNT_W'(fill_eff + 1'b1);
      end
      if (cfg_we) begin
        k_in_use_r <= cfg_data;
      end
    end
  end

  // Vote: one kept class per cycle from the head of the snapshot line
  logic [3:0]       head;
  logic             hit;
  logic [VW-1:0]    cidx;
  logic [CNT_W-1:0] new_cnt;
  logic             better;

  assign head    = snap_r[0];
  assign hit     = (int'(head) < NUM_CLASSES);
  assign cidx    = head[VW-1:0];
  assign new_cnt = CNT_W'(cnt_r[cidx] + 1'b1);
  assign better  = (new_cnt > most_r) || ((new_cnt == most_r) && (head < best_r));

  for (genvar gj = 0; gj < NV; gj++) begin : g_cnt
    always_ff @(posedge clk) begin
      if (cmd.vote_load) begin
        cnt_r[gj] <= '0;
      end else if (cmd.vote_step && hit && (cidx == VW'(gj))) begin
        cnt_r[gj] <= new_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vote_load) begin
      idx_r  <= '0;
      nf_r   <= fill_eff;
      most_r <= '0;
      best_r <= 4'd0;
    end else if (cmd.vote_step) begin
      idx_r <= CNT_W'(idx_r + 1'b1);
      if (hit && better) begin
        most_r <= new_cnt;
        best_r <= head;
      end
    end
  end

  assign status.vote_done = (idx_r == nf_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.best_class <= best_r;
      out_data_r.found      <= (nf_r != '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hdl/knn_chk.sv
// Port-level checker for the k-NN top-k block, bound to the top level.
// Depends on knn_pkg and knn_top_k_insert_and_vote_top.
`default_nettype none

module knn_chk
  import knn_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire in_t        in_data,
  input wire logic       out_valid,
  input wire out_t       out_data,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready,
  input wire logic [4:0] cfg_data
);

  // A vote result never follows another in the next cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // The result shows only once the count is over
  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  a_empty_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.best_class == 4'd0))
    else $error("nonzero class with empty list");

  a_vote_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.opcode == OP_VOTE) |=> busy)
    else $error("vote did not start counting");

  a_fast_items: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.opcode != OP_VOTE) |=> (!busy && !out_valid))
    else $error("single-cycle item stalled or gave a result");

endmodule

bind knn_top_k_insert_and_vote_top knn_chk u_chk (.*);

`default_nettype wire

### tb/tb_knn_top_k_insert_and_vote_top.sv
`timescale 1ns / 1ps
// Testbench for knn_top_k_insert_and_vote_top: directed and random offer, vote, clear, unused-opcode
// items and k writes against a behavioral top-k list model, checking every vote result as it comes out.
// Depends on knn_pkg and the RTL of the block.

module tb_knn_top_k_insert_and_vote_top;
  import knn_pkg::*;

  localparam int MAX_K = 16;
  localparam int NUM_CLASSES = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = MAX_K + 4;
  localparam int RANDOM_ITEMS = 1900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_data = '0;

  // Expected top-k list, kept in step with every accepted item
  logic signed [15:0] kept_score [MAX_K];
  logic [3:0] kept_class [MAX_K];
  int unsigned fill;
  logic [4:0] k_reg;

  out_t pending_votes [$];
  int err_count = 0;
  int unsigned cycles = 0;
  bit gaps_on = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  knn_top_k_insert_and_vote_top #(
    .MAX_K(MAX_K),
    .NUM_CLASSES(NUM_CLASSES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  function automatic int unsigned active_k();
    if (k_reg == 5'd0) return 1;
    if (k_reg > MAX_K) return MAX_K;
    return k_reg;
  endfunction

  function automatic void clear_list();
    for (int i = 0; i < MAX_K; i++) begin
      kept_score[i] = SENTINEL_SCORE;
      kept_class[i] = '0;
    end
    fill = 0;
  endfunction

  function automatic void insert_candidate(logic signed [15:0] s, logic [3:0] c);
    int unsigned k, f, pos, i;
    k = active_k();
    f = (fill < k) ? fill : k;
    pos = 0;
    if (s == SENTINEL_SCORE) return;
    if (f == k && s <= kept_score[k - 1]) return;
    // land after any equal scores
    while (pos < f && kept_score[pos] >= s) pos++;
    i = (f < k) ? f : k - 1;
    while (i > pos) begin
      kept_score[i] = kept_score[i - 1];
      kept_class[i] = kept_class[i - 1];
      i--;
    end
    kept_score[pos] = s;
    kept_class[pos] = c;
    fill = (f < k) ? f + 1 : k;
  endfunction

  function automatic out_t majority_vote();
    int unsigned tally [NUM_CLASSES];
    int unsigned k, f, most;
    out_t r;
    k = active_k();
    f = (fill < k) ? fill : k;
    most = 0;
    r = '0;
    for (int c = 0; c < NUM_CLASSES; c++) tally[c] = 0;
    for (int i = 0; i < f; i++) begin
      if (kept_class[i] < NUM_CLASSES) tally[kept_class[i]]++;
    end
    // strict compare keeps the lowest class on a tie
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (tally[c] > most) begin
        most = tally[c];
        r.best_class = 4'(c);
      end
    end
    r.found = (f > 0);
    return r;
  endfunction

  function automatic int unsigned random_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  function automatic logic signed [15:0] random_score();
    int unsigned r;
    int v;
    r = $urandom_range(99);
    if (r < 40) return 16'($urandom());
    if (r < 70) begin
      // coarse grid so equal scores are common
      v = int'($urandom_range(6)) - 3;
      return 16'(v * 4096);
    end
    if (r < 90) begin
      // hover around the last kept score
      v = int'(kept_score[active_k() - 1]) + int'($urandom_range(2)) - 1;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return 16'(v);
    end
    case ($urandom_range(3))
      0: return SENTINEL_SCORE;
      1: return 16'sh8001;
      2: return 16'sh7fff;
      default: return '0;
    endcase
  endfunction

  // Send one item, wait for the handshake, update the model, then idle for a random gap that may be zero
  task automatic send_item(input logic [1:0] op, input logic signed [15:0] s,
                           input logic [3:0] c);
    in_t it;
    int unsigned gap;
    it.opcode = op;
    it.score = s;
    it.class_id = c;
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    case (op)
      OP_OFFER: insert_candidate(s, c);
      OP_VOTE:  pending_votes.push_back(majority_vote());
      OP_CLEAR: clear_list();
      default: ;
    endcase
    gap = random_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every vote result is back and the block has gone quiet
  task automatic drain();
    start <= 1'b0;
    while (pending_votes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_k(input logic [4:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    k_reg = v;
  endtask

  task automatic test_empty_list();
    send_item(OP_VOTE, '0, '0);
    send_item(OP_UNUSED, 16'sh5a5a, 4'ha);
    // the sentinel score never goes in, even with room to spare
    send_item(OP_OFFER, SENTINEL_SCORE, 4'd7);
    send_item(OP_VOTE, 16'sh7fff, 4'hf);
  endtask

  task automatic test_extremes();
    send_item(OP_OFFER, 16'sh7fff, 4'd15);
    send_item(OP_OFFER, 16'sh8001, 4'd0);
    send_item(OP_OFFER, '0, 4'd5);
    send_item(OP_OFFER, '0, 4'd6);
    send_item(OP_OFFER, '0, 4'd5);
    send_item(OP_OFFER, 16'sh7fff, 4'd3);
    send_item(OP_VOTE, '0, '0);
    send_item(OP_CLEAR, 16'sh1234, 4'd9);
    send_item(OP_VOTE, '0, '0);
  endtask

  task automatic test_full_short_list();
    write_k(5'd3);
    send_item(OP_OFFER, 16'sd100, 4'd1);
    send_item(OP_OFFER, 16'sd200, 4'd2);
    send_item(OP_OFFER, 16'sd300, 4'd3);
    // equal to the last entry of a full list: dropped
    send_item(OP_OFFER, 16'sd100, 4'd9);
    send_item(OP_OFFER, 16'sd150, 4'd9);
    send_item(OP_VOTE, '0, '0);
  endtask

  task automatic test_k_shrink();
    write_k(5'd6);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_OFFER, 16'sd600, 4'd4);
    send_item(OP_OFFER, 16'sd500, 4'd4);
    send_item(OP_OFFER, 16'sd400, 4'd7);
    send_item(OP_OFFER, 16'sd300, 4'd7);
    send_item(OP_OFFER, 16'sd200, 4'd7);
    send_item(OP_OFFER, 16'sd100, 4'd1);
    send_item(OP_VOTE, '0, '0);
    // shrink k while filled: only the head of the list counts
    write_k(5'd2);
    send_item(OP_VOTE, '0, '0);
    send_item(OP_OFFER, 16'sd550, 4'd9);
    send_item(OP_VOTE, '0, '0);
    write_k(5'd6);
    send_item(OP_VOTE, '0, '0);
  endtask

  task automatic test_random();
    int unsigned sent, phase, len, r;
    logic [4:0] k_next;
    logic [1:0] op;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: k_next = 5'd0;
        1: k_next = 5'd31;
        2: k_next = 5'd1;
        3: k_next = 5'd17;
        4: k_next = 5'd16;
        5: k_next = 5'd2;
        default: k_next = ($urandom_range(2) == 0) ? 5'($urandom_range(31))
                                                    : 5'($urandom_range(16, 1));
      endcase
      write_k(k_next);
      gaps_on = ($urandom_range(3) != 0);
      // leave the list filled now and then so the new k meets old entries
      if ($urandom_range(2) != 0) begin
        send_item(OP_CLEAR, 16'($urandom()), 4'($urandom()));
        sent++;
      end
      len = $urandom_range(140, 40);
      repeat (len) begin
        r = $urandom_range(99);
        if (r < 78) op = OP_OFFER;
        else if (r < 92) op = OP_VOTE;
        else if (r < 96) op = OP_CLEAR;
        else op = OP_UNUSED;
        if (op == OP_OFFER) send_item(op, random_score(), 4'($urandom()));
        else send_item(op, 16'($urandom()), 4'($urandom()));
        if (op != OP_UNUSED) sent++;
      end
      phase++;
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_votes.size() == 0) begin
        $error("unexpected vote result: best_class=%0d found=%0b",
               out_data.best_class, out_data.found);
        err_count++;
      end else begin
        want = pending_votes.pop_front();
        if (out_data.best_class !== want.best_class) begin
          $error("best_class: expected %0d, got %0d", want.best_class, out_data.best_class);
          err_count++;
        end
        if (out_data.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_data.found);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_knn_top_k_insert_and_vote_top: done, errors");
      $finish;
    end
  end

  initial begin
    clear_list();
    k_reg = K_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_extremes();
    test_full_short_list();
    test_k_shrink();
    test_random();
    drain();
    if (err_count == 0) begin
      $display("tb_knn_top_k_insert_and_vote_top: done, clean");
    end else begin
      $display("tb_knn_top_k_insert_and_vote_top: done, errors");
    end
    $finish;
  end

endmodule
